// ===== rtl/sfd_pkg.sv =====
package sfd_pkg;

	localparam int FRAME_BYTES    = 25;
	localparam int POS_W          = $clog2(FRAME_BYTES);
	localparam int CH_W           = 11;
	localparam int CH_COUNT       = 16;
	localparam int IDX_W          = $clog2(CH_COUNT);
	localparam int ACC_W          = CH_W + 7;
	localparam int CNT_W          = $clog2(ACC_W + 1);

	localparam logic [POS_W-1:0] FRAME_LAST     = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] FRAME_LIMIT    = POS_W'(FRAME_BYTES);
	localparam logic [POS_W-1:0] FLAGS_POSITION = POS_W'(23);
	localparam logic [POS_W-1:0] PAYLOAD_FIRST  = POS_W'(1);
	localparam logic [POS_W-1:0] PAYLOAD_LAST   = POS_W'(22);
	localparam logic [2:0]       FAILSAFE_BIT   = 3'd3;
	localparam logic [IDX_W-1:0] CH_LAST        = IDX_W'(CH_COUNT - 1);

	localparam logic [7:0] HEADER_RESET = 8'd15;
	localparam logic [7:0] FOOTER_RESET = 8'd0;
	localparam logic [7:0] PREV_RESET   = 8'hFF;

	typedef enum logic {
		REG_HEADER = 1'b0,
		REG_FOOTER = 1'b1
	} sfd_reg_t;

	typedef enum logic {
		SFD_IDLE   = 1'b0,
		SFD_UNPACK = 1'b1
	} sfd_state_t;

	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] addr;
		logic [7:0]       data;
	} sfd_wr_t;

	typedef struct packed {
		logic start;
		logic failsafe;
	} sfd_ctl_t;

endpackage

// ===== rtl/sbus_frame_decoder.sv =====
// channel | handshake            | payload
// in      | in_valid / in_ready  | rx_byte[7:0]
// out     | out_valid / out_ready| channel_index[3:0], channel_value[10:0], failsafe, last_channel
// cfg     | cfg_we               | cfg_index[0], cfg_data[7:0]
//
// A byte is taken whenever in_valid and in_ready are both high. A good footer starts the unpacker,
// which reads payload bytes 1..22 from the frame memory over its single read port, only while
// fewer than 11 bits are held or pending, and gives the sixteen channels; in_ready is low meanwhile.
// Reset: hunting, previous byte 0xFF, header 15, footer 0. Frame memory is not cleared.
// A stalled out beat holds the unpacker; bytes are still taken while it holds the last one.
module sbus_frame_decoder
	import sfd_pkg::*;
#(
	parameter logic [2:0] FAILSAFE_BIT_INDEX = FAILSAFE_BIT
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] channel_index,
	output logic [CH_W-1:0]  channel_value,
	output logic             failsafe,
	output logic             last_channel
);

	logic [7:0]       header_q, footer_q, prev_q;
	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic             fs_flag_q;
	logic             busy, accept, open, frame_end;
	sfd_wr_t          wr;
	sfd_ctl_t         ctl;

	assign in_ready  = !busy;
	assign accept    = in_valid && in_ready;
	assign open      = !in_frame_q && (rx_byte == header_q) && (prev_q == footer_q);
	assign frame_end = in_frame_q && (pos_q >= FRAME_LAST);

	always_comb begin
		wr.en        = accept && (open || (in_frame_q && pos_q < FRAME_LIMIT));
		wr.addr      = open ? '0 : pos_q;
		wr.data      = rx_byte;
		ctl.start    = accept && frame_end && (rx_byte == footer_q);
		ctl.failsafe = fs_flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= HEADER_RESET;
			footer_q   <= FOOTER_RESET;
			prev_q     <= PREV_RESET;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (sfd_reg_t'(cfg_index))
					REG_HEADER: header_q <= cfg_data;
					REG_FOOTER: footer_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (!in_frame_q) begin
					if (open) begin
						in_frame_q <= 1'b1;
						pos_q      <= POS_W'(1);
					end else begin
						prev_q <= rx_byte;
					end
				end else if (frame_end) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
					prev_q     <= rx_byte;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_frame_q && pos_q == FLAGS_POSITION)
			fs_flag_q <= rx_byte[FAILSAFE_BIT_INDEX];
	end

	sfd_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr            (wr),
		.ctl           (ctl),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.failsafe      (failsafe),
		.last_channel  (last_channel)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> !in_ready)
		else $error("unpacker did not go busy after a good footer");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_channel) |-> (channel_index == CH_LAST))
		else $error("last channel flag on wrong index");

	a_no_early_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_frame_q && pos_q < FRAME_LAST) |-> !ctl.start)
		else $error("unpack started before frame end");

	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (pos_q != '0))
		else $error("open frame at position zero");

endmodule

// ===== rtl/sfd_unpack.sv =====
module sfd_unpack
	import sfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  sfd_wr_t          wr,
	input  sfd_ctl_t         ctl,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] channel_index,
	output logic [CH_W-1:0]  channel_value,
	output logic             failsafe,
	output logic             last_channel
);

	logic [7:0] mem [FRAME_BYTES];

	sfd_state_t       state_q, state_nx;
	logic [POS_W-1:0] rd_addr_q;
	logic             rd_pend_s1;
	logic [7:0]       rd_data_s1;
	logic [ACC_W-1:0] acc_q, acc_sh, acc_nx;
	logic [CNT_W-1:0] cnt_q, cnt_sh, cnt_nx, cnt_eff;
	logic [IDX_W-1:0] chan_q;
	logic             fs_q;
	logic             emit, issue, done;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_index_q;
	logic [CH_W-1:0]  out_value_q;
	logic             out_fs_q;
	logic             out_last_q;

	// outputs of the sequencer
	always_comb begin
		cnt_eff = cnt_q + (rd_pend_s1 ? CNT_W'(8) : CNT_W'(0));
		emit    = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			SFD_IDLE: begin
			end
			SFD_UNPACK: begin
				emit  = (cnt_q >= CNT_W'(CH_W)) && (!out_valid_q || out_ready);
				issue = (rd_addr_q <= PAYLOAD_LAST) && (cnt_eff < CNT_W'(CH_W));
			end
			default: begin
			end
		endcase
		done = emit && (chan_q == CH_LAST);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			SFD_IDLE:   if (ctl.start) state_nx = SFD_UNPACK;
			SFD_UNPACK: if (done) state_nx = SFD_IDLE;
			default:    state_nx = SFD_IDLE;
		endcase
	end

	always_comb begin
		acc_sh = emit ? (acc_q >> CH_W) : acc_q;
		cnt_sh = emit ? (cnt_q - CNT_W'(CH_W)) : cnt_q;
		acc_nx = acc_sh;
		cnt_nx = cnt_sh;
		if (rd_pend_s1) begin
			acc_nx = acc_sh | (ACC_W'(rd_data_s1) << cnt_sh);
			cnt_nx = cnt_sh + CNT_W'(8);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (issue)
			rd_data_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SFD_IDLE;
			rd_addr_q   <= PAYLOAD_FIRST;
			rd_pend_s1  <= 1'b0;
			cnt_q       <= '0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			rd_pend_s1 <= issue;
			if (ctl.start && state_q == SFD_IDLE) begin
				rd_addr_q <= PAYLOAD_FIRST;
				cnt_q     <= '0;
				chan_q    <= '0;
			end else begin
				cnt_q <= cnt_nx;
				if (issue)
					rd_addr_q <= rd_addr_q + POS_W'(1);
				if (emit)
					chan_q <= chan_q + IDX_W'(1);
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && state_q == SFD_IDLE) begin
			acc_q <= '0;
			fs_q  <= ctl.failsafe;
		end else begin
			acc_q <= acc_nx;
		end
		if (emit) begin
			out_index_q <= chan_q;
			out_value_q <= acc_q[CH_W-1:0];
			out_fs_q    <= fs_q;
			out_last_q  <= (chan_q == CH_LAST);
		end
	end

	assign busy          = (state_q != SFD_IDLE);
	assign out_valid     = out_valid_q;
	assign channel_index = out_index_q;
	assign channel_value = out_value_q;
	assign failsafe      = out_fs_q;
	assign last_channel  = out_last_q;

endmodule
